// ===== hw/rtl/pc_pkg.sv =====
// pc_pkg: widths, status codes and shared types of the polygon centroid block
// no dependencies; compile first
package pc_pkg;

    // coordinate and result formats
    localparam int COORD_W      = 16;
    localparam int FRAC_W       = 8;
    localparam int OUT_W        = 24;
    localparam int MAX_VERTICES = 256;

    // vertex counter holds up to MAX_VERTICES+1 (overflow mark)
    localparam int COUNT_W = $clog2(MAX_VERTICES + 2);

    // edge datapath: cross product, coordinate sum, moment product
    localparam int D_W    = 2 * COORD_W + 1;
    localparam int SUM_W  = COORD_W + 1;
    localparam int PROD_W = D_W + SUM_W;

    // accumulators, exact for polygons of up to MAX_VERTICES vertices
    localparam int AREA_W = D_W + $clog2(MAX_VERTICES);
    localparam int MOM_W  = AREA_W + SUM_W;

    // divider: magnitudes, remainder and quotient step count
    localparam int NUM_W     = MOM_W;
    localparam int DEN_W     = AREA_W + 1;
    localparam int QB        = OUT_W - 1;
    localparam int REM_W     = DEN_W + QB;
    localparam int SAT_SHIFT = OUT_W - 1 - FRAC_W;
    localparam int STEP_W    = $clog2(QB);

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_ZERO_AREA = 2'd1,
        ST_OVERFLOW  = 2'd2
    } status_t;

    // divider result as seen by the sequencer
    typedef struct packed {
        logic                    done;
        logic signed [OUT_W-1:0] value;
    } div_res_t;

endpackage

// ===== hw/rtl/pc_vertex_if.sv =====
// pc_vertex_if: valid/ready channel carrying one polygon vertex per beat
// depends on pc_pkg
interface pc_vertex_if import pc_pkg::*; ();

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] vertex_x;
    logic signed [COORD_W-1:0] vertex_y;
    logic                      is_last;

    modport source (output valid, output vertex_x, output vertex_y, output is_last,
                    input ready);
    modport sink   (input valid, input vertex_x, input vertex_y, input is_last,
                    output ready);

endinterface

// ===== hw/rtl/pc_centroid_if.sv =====
// pc_centroid_if: valid/ready channel carrying one centroid result per beat
// depends on pc_pkg
interface pc_centroid_if import pc_pkg::*; ();

    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] centroid_x;
    logic signed [OUT_W-1:0] centroid_y;
    status_t                 status;

    modport source (output valid, output centroid_x, output centroid_y, output status,
                    input ready);
    modport sink   (input valid, input centroid_x, input centroid_y, input status,
                    output ready);

endinterface

// ===== hw/rtl/pc_divider.sv =====
// pc_divider: moment / (3 * area) in fixed point, rounded and saturated
// restoring divider, one quotient bit per cycle; depends on pc_pkg
module pc_divider import pc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic signed [MOM_W-1:0]  moment,
    input  logic signed [AREA_W-1:0] area,
    output div_res_t                 res
);

    typedef enum logic [4:0] {
        D_IDLE  = 5'b00001,
        D_SAT   = 5'b00010,
        D_ITER  = 5'b00100,
        D_ROUND = 5'b01000,
        D_FIX   = 5'b10000
    } dstate_t;

    localparam logic [OUT_W-1:0] LIM = OUT_W'(1) << (OUT_W - 1);

    dstate_t                 state_reg, state_next;
    logic [NUM_W-1:0]        num_reg;
    logic [DEN_W-1:0]        den_reg;
    logic                    neg_reg;
    logic [REM_W-1:0]        rem_reg;
    logic [REM_W-1:0]        dsh_reg;
    logic [QB-1:0]           q_reg;
    logic [STEP_W-1:0]       step_reg;
    logic [OUT_W-1:0]        mag_reg;
    logic                    done_reg;
    logic signed [OUT_W-1:0] value_reg;

    logic [AREA_W-1:0]   area_mag;
    logic [NUM_W-1:0]    mom_mag;
    logic                sat;
    logic                ge;
    logic                rnd;

    // operand magnitudes
    assign area_mag = area[AREA_W-1] ? AREA_W'(-area) : AREA_W'(area);
    assign mom_mag  = moment[MOM_W-1] ? NUM_W'(-moment) : NUM_W'(moment);

    // integer part already at or above the output range
    assign sat = REM_W'(num_reg) >= (REM_W'(den_reg) << SAT_SHIFT);
    assign ge  = rem_reg >= dsh_reg;
    assign rnd = {rem_reg[DEN_W-1:0], 1'b0} >= {1'b0, den_reg};

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE:  if (start) state_next = D_SAT;
            D_SAT:   state_next = sat ? D_FIX : D_ITER;
            D_ITER:  if (step_reg == '0) state_next = D_ROUND;
            D_ROUND: state_next = D_FIX;
            D_FIX:   state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == D_FIX);
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            D_IDLE:
            begin
                num_reg <= mom_mag;
                den_reg <= DEN_W'(area_mag) + {area_mag, 1'b0};
                neg_reg <= moment[MOM_W-1] ^ area[AREA_W-1];
            end
            D_SAT:
            begin
                mag_reg  <= LIM;
                rem_reg  <= REM_W'(num_reg) << FRAC_W;
                dsh_reg  <= REM_W'(den_reg) << (QB - 1);
                q_reg    <= '0;
                step_reg <= STEP_W'(QB - 1);
            end
            D_ITER:
            begin
                if (ge)
                    rem_reg <= rem_reg - dsh_reg;
                q_reg    <= {q_reg[QB-2:0], ge};
                dsh_reg  <= dsh_reg >> 1;
                step_reg <= step_reg - STEP_W'(1);
            end
            D_ROUND:
            begin
                mag_reg <= OUT_W'(q_reg) + OUT_W'(rnd);
            end
            D_FIX:
            begin
                if (neg_reg)
                    value_reg <= -mag_reg;
                else if (mag_reg > LIM - OUT_W'(1))
                    value_reg <= LIM - OUT_W'(1);
                else
                    value_reg <= mag_reg;
            end
            default: ;
        endcase
    end

    assign res.done  = done_reg;
    assign res.value = value_reg;

endmodule

// ===== hw/rtl/polygon_centroid_top.sv =====
// polygon_centroid_top: shoelace centroid of a polygon streamed vertex by vertex
// depends on pc_pkg, pc_vertex_if, pc_centroid_if, pc_divider
//
//  channel    dir   beat carries                            handshake
//  vertex     in    vertex_x, vertex_y, is_last             valid/ready
//  centroid   out   centroid_x, centroid_y, status          valid/ready
//
// a vertex is accepted in S_IDLE, then runs S_M1 to S_M5 on the shared multiplier (four products
// per edge); the first vertex of a polygon is only stored, unless it is also the last
// the closing vertex adds its own edge and the closing edge (no edges once the count overflowed),
// then, unless overflowed or of zero area, two bit-serial divisions, x then y; a saturated one skips its iterations
// vertex.ready is high only while the sequencer is idle; the result sits in an output
// register, and the next polygon is taken while it waits
// async active-low reset clears the sums, the counter and all handshake state
module polygon_centroid_top import pc_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    pc_vertex_if.sink     vertex,
    pc_centroid_if.source centroid
);

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_M1   = 10'b0000000010,
        S_M2   = 10'b0000000100,
        S_M3   = 10'b0000001000,
        S_M4   = 10'b0000010000,
        S_M5   = 10'b0000100000,
        S_EVAL = 10'b0001000000,
        S_DIVX = 10'b0010000000,
        S_DIVY = 10'b0100000000,
        S_FIN  = 10'b1000000000
    } state_t;

    localparam logic [COUNT_W-1:0] CNT_MAX = COUNT_W'(MAX_VERTICES);
    localparam logic [COUNT_W-1:0] CNT_OVF = COUNT_W'(MAX_VERTICES + 1);

    state_t                     state_reg, state_next;
    logic [COUNT_W-1:0]         count_reg;
    logic signed [AREA_W-1:0]   area_reg;
    logic signed [MOM_W-1:0]    mx_reg;
    logic signed [MOM_W-1:0]    my_reg;
    logic                       last_reg;
    logic                       close_reg;
    logic                       out_valid_reg;

    logic signed [COORD_W-1:0]  cur_x_reg, cur_y_reg;
    logic signed [COORD_W-1:0]  first_x_reg, first_y_reg;
    logic signed [COORD_W-1:0]  prev_x_reg, prev_y_reg;
    logic signed [COORD_W-1:0]  ea_x_reg, ea_y_reg;
    logic signed [COORD_W-1:0]  eb_x_reg, eb_y_reg;
    logic signed [PROD_W-1:0]   p_reg;
    logic signed [D_W-1:0]      d_reg;
    logic signed [OUT_W-1:0]    res_x_reg, res_y_reg;
    status_t                    res_st_reg;
    logic signed [OUT_W-1:0]    out_x_reg, out_y_reg;
    status_t                    out_st_reg;

    logic                       in_fire;
    logic                       out_load;
    logic                       div_start;
    logic signed [SUM_W-1:0]    mul_a;
    logic signed [D_W-1:0]      mul_b;
    logic signed [PROD_W-1:0]   prod;
    div_res_t                   div_res;

    assign vertex.ready = (state_reg == S_IDLE);
    assign in_fire      = vertex.valid && vertex.ready;
    assign out_load     = (state_reg == S_FIN) && (!out_valid_reg || centroid.ready);

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_M2:
            begin
                mul_a = SUM_W'(eb_x_reg);
                mul_b = D_W'(ea_y_reg);
            end
            S_M3:
            begin
                mul_a = SUM_W'(ea_x_reg) + SUM_W'(eb_x_reg);
                mul_b = d_reg;
            end
            S_M4:
            begin
                mul_a = SUM_W'(ea_y_reg) + SUM_W'(eb_y_reg);
                mul_b = d_reg;
            end
            default:
            begin
                mul_a = SUM_W'(ea_x_reg);
                mul_b = D_W'(eb_y_reg);
            end
        endcase
    end

    assign prod = mul_a * mul_b;

    // divider runs x then y, started from the sequencer
    assign div_start = ((state_reg == S_EVAL) && (count_reg != CNT_OVF) && (area_reg != '0))
                    || ((state_reg == S_DIVX) && div_res.done);

    pc_divider u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .moment ((state_reg == S_DIVX) ? my_reg : mx_reg),
        .area   (area_reg),
        .res    (div_res)
    );

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    if (count_reg == '0)
                        state_next = vertex.is_last ? S_M1 : S_IDLE;
                    else if (count_reg < CNT_MAX)
                        state_next = S_M1;
                    else
                        state_next = vertex.is_last ? S_EVAL : S_IDLE;
                end
            end
            S_M1: state_next = S_M2;
            S_M2: state_next = S_M3;
            S_M3: state_next = S_M4;
            S_M4: state_next = S_M5;
            S_M5:
            begin
                if (last_reg && !close_reg)
                    state_next = S_M1;
                else if (last_reg)
                    state_next = S_EVAL;
                else
                    state_next = S_IDLE;
            end
            S_EVAL: state_next = div_start ? S_DIVX : S_FIN;
            S_DIVX: if (div_res.done) state_next = S_DIVY;
            S_DIVY: if (div_res.done) state_next = S_FIN;
            S_FIN:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    // control state, counter and accumulators
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            area_reg      <= '0;
            mx_reg        <= '0;
            my_reg        <= '0;
            last_reg      <= 1'b0;
            close_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // vertex beat: count and closing flags
            if (in_fire)
            begin
                last_reg <= vertex.is_last;
                if (count_reg == '0)
                begin
                    count_reg <= COUNT_W'(1);
                    close_reg <= vertex.is_last;
                end
                else
                begin
                    close_reg <= 1'b0;
                    if (count_reg < CNT_MAX)
                        count_reg <= count_reg + COUNT_W'(1);
                    else
                        count_reg <= CNT_OVF;
                end
            end

            if ((state_reg == S_M5) && last_reg)
                close_reg <= 1'b1;

            // shoelace accumulation
            if (state_reg == S_M3)
                area_reg <= area_reg + AREA_W'(d_reg);
            if (state_reg == S_M4)
                mx_reg <= mx_reg + MOM_W'(p_reg);
            if (state_reg == S_M5)
                my_reg <= my_reg + MOM_W'(p_reg);

            // result handed over: clear the polygon state
            if (out_load)
            begin
                count_reg <= '0;
                area_reg  <= '0;
                mx_reg    <= '0;
                my_reg    <= '0;
                last_reg  <= 1'b0;
                close_reg <= 1'b0;
            end

            // output register valid
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (centroid.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // vertex storage and edge operands
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_x_reg  <= vertex.vertex_x;
            cur_y_reg  <= vertex.vertex_y;
            prev_x_reg <= vertex.vertex_x;
            prev_y_reg <= vertex.vertex_y;
            if (count_reg == '0)
            begin
                first_x_reg <= vertex.vertex_x;
                first_y_reg <= vertex.vertex_y;
                ea_x_reg    <= vertex.vertex_x;
                ea_y_reg    <= vertex.vertex_y;
            end
            else
            begin
                ea_x_reg <= prev_x_reg;
                ea_y_reg <= prev_y_reg;
            end
            eb_x_reg <= vertex.vertex_x;
            eb_y_reg <= vertex.vertex_y;
        end
        else if ((state_reg == S_M5) && last_reg && !close_reg)
        begin
            // closing edge: last vertex to first
            ea_x_reg <= cur_x_reg;
            ea_y_reg <= cur_y_reg;
            eb_x_reg <= first_x_reg;
            eb_y_reg <= first_y_reg;
        end

        // products and cross product
        if ((state_reg == S_M1) || (state_reg == S_M3) || (state_reg == S_M4))
            p_reg <= prod;
        if (state_reg == S_M2)
            d_reg <= D_W'(p_reg - prod);

        // result fields
        if (state_reg == S_EVAL)
        begin
            res_x_reg <= '0;
            res_y_reg <= '0;
            if (count_reg == CNT_OVF)
                res_st_reg <= ST_OVERFLOW;
            else if (area_reg == '0)
                res_st_reg <= ST_ZERO_AREA;
            else
                res_st_reg <= ST_OK;
        end
        if ((state_reg == S_DIVX) && div_res.done)
            res_x_reg <= div_res.value;
        if ((state_reg == S_DIVY) && div_res.done)
            res_y_reg <= div_res.value;

        // output register
        if (out_load)
        begin
            out_x_reg  <= res_x_reg;
            out_y_reg  <= res_y_reg;
            out_st_reg <= res_st_reg;
        end
    end

    assign centroid.valid      = out_valid_reg;
    assign centroid.centroid_x = out_x_reg;
    assign centroid.centroid_y = out_y_reg;
    assign centroid.status     = out_st_reg;

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_OVF)
        else $error("vertex count beyond overflow mark");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (centroid.valid && (centroid.status != ST_OK))
            |-> (centroid.centroid_x == '0) && (centroid.centroid_y == '0))
        else $error("non-ok result with nonzero centroid");

    a_out_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FIN))
        else $error("result valid without finishing a polygon");

    a_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_load |=> (count_reg == '0) && (area_reg == '0) && (mx_reg == '0)
                     && (my_reg == '0))
        else $error("polygon state not cleared after result");

    a_div_done: assert property (@(posedge clk) disable iff (!rst_n)
        div_res.done |-> (state_reg == S_DIVX) || (state_reg == S_DIVY))
        else $error("divider finished outside a division step");
`endif

endmodule
